FILE: rtl/lin_master_schedule_engine_core_macros.svh
// Assertion helpers for the schedule engine.
// Every check runs on the rising clock edge and is disabled during reset.
`ifndef LIN_MASTER_SCHEDULE_ENGINE_CORE_MACROS_SVH
`define LIN_MASTER_SCHEDULE_ENGINE_CORE_MACROS_SVH

// The condition must hold at every clock edge.
`define LMSE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define LMSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LMSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/lmse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lmse_pkg;

    // Input command codes carried in the slave tuser.
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_WR_SLOT  = 3'd1;
    localparam logic [2:0] CMD_WR_MSG   = 3'd2;
    localparam logic [2:0] CMD_WR_TXD   = 3'd3;
    localparam logic [2:0] CMD_FRAME    = 3'd4;
    localparam logic [2:0] CMD_RD_RX    = 3'd5;

    // Result kinds carried in the master tuser.
    localparam logic [1:0] KIND_FRAME   = 2'd0;
    localparam logic [1:0] KIND_HEADER  = 2'd1;
    localparam logic [1:0] KIND_STATUS  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLE     = 2'd0;
    localparam logic [1:0] CFG_SLOT_COUNT = 2'd1;
    localparam logic [1:0] CFG_RX_COUNT   = 2'd2;

    // Highest valid LIN frame identifier.
    localparam logic [7:0] MAX_LIN_ID = 8'h3F;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TK_SLOT,
        ST_TK_MSG,
        ST_TK_GAP,
        ST_SR_CHK,
        ST_SR_UPD,
        ST_RD_DATA,
        ST_EMIT
    } t_state;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic [5:0]  id;
        logic [3:0]  dlc;
        logic [63:0] data;
        logic        rcv;
        logic        tmo;
    } t_result;

    // Mask covering the first dlc bytes; lengths of eight and more cover all.
    function automatic logic [63:0] byte_mask(input logic [3:0] dlc);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < dlc) begin
                m[b*8 +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lmse_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port synchronous RAM with registered read data.
module lmse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/lin_master_schedule_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "lin_master_schedule_engine_core_macros.svh"
// LIN master schedule engine for one bus.
// Command words enter on the slave stream (command in tuser, fields in tdata);
// results leave on the master stream (kind in tuser). Registers enable,
// slot_count and rx_count must be written through the cfg channel only while
// idle; the block itself does not enforce this. Table writes (slot, message
// entry, tx data) complete in the accept cycle. A tick that reaches a slot
// steps through schedule read, message read, status write back and next gap
// read, then the result word is loaded. A received frame walks the receive
// table one entry per cycle over its single read port. One command is in
// flight at a time; the next is taken once the sequencer is back in idle,
// also while a result still waits in the output register. A stalled receiver
// holds that register; a second result then waits in the sequencer until the
// first word is taken.
// Reset clears the registers, slot position, gap counter and all receive
// status; schedule, message and tx data memories hold garbage until written.
module lin_master_schedule_engine_core #(
    parameter int SLOTS       = 16,
    parameter int MSG_ENTRIES = 16,
    parameter int GAP_BITS    = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // Command stream.
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata from bit 0: entry_index(4) slot_is_tx(1) slot_msg_index(4) slot_gap(16)
    // table_is_tx(1) msg_id(6) msg_dlc(4) frame_id(8) frame_dlc(4) frame_data(64)
    input  wire logic [111:0] i_s_tdata,
    // tuser: command(3)
    input  wire logic [2:0]   i_s_tuser,
    // Result stream.
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata from bit 0: out_id(6) out_dlc(4) out_data(64) out_received(1)
    // out_timeout(1), zero padding(4)
    output logic      [79:0]  o_m_tdata,
    // tuser: result_kind(2)
    output logic      [1:0]   o_m_tuser,
    // Configuration writes.
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [4:0]   i_cfg_data
);

    localparam int SA_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MA_W   = (MSG_ENTRIES > 1) ? $clog2(MSG_ENTRIES) : 1;
    localparam int SCH_W  = 1 + 4 + GAP_BITS;
    localparam int STAT_W = 2 + 64;

    // Configuration registers.
    logic       r_enable;
    logic [4:0] r_slot_count;
    logic [4:0] r_rx_count;

    // Sequencer and schedule state.
    lmse_pkg::t_state  r_state, n_state;
    logic [SA_W-1:0]   r_pos;
    logic [GAP_BITS-1:0] r_gap;
    logic              r_slot_tx;
    logic              r_slot_ok;
    logic [MA_W-1:0]   r_slot_msg;
    logic [MA_W-1:0]   r_srch_i;
    logic [5:0]        r_fid;
    logic [3:0]        r_fdlc;
    logic [63:0]       r_fdata;
    logic              r_dlc_ok;
    logic [MSG_ENTRIES-1:0] r_stat_vld;
    logic              r_stat_rv;
    lmse_pkg::t_result r_res;
    lmse_pkg::t_result r_out;
    logic              r_out_valid;

    // Input field unpacking.
    logic        w_acc;
    logic [2:0]  w_cmd;
    logic [3:0]  w_idx;
    logic [6:0]  w_idx_ext;
    logic        w_idx_slot_ok;
    logic        w_idx_msg_ok;
    logic        w_slot_is_tx;
    logic [3:0]  w_slot_msg;
    logic [15:0] w_slot_gap;
    logic        w_table_is_tx;
    logic [5:0]  w_msg_id;
    logic [3:0]  w_msg_dlc;
    logic [7:0]  w_frame_id;
    logic [3:0]  w_frame_dlc;
    logic [63:0] w_frame_data;

    assign w_cmd         = i_s_tuser;
    assign w_idx         = i_s_tdata[3:0];
    assign w_slot_is_tx  = i_s_tdata[4];
    assign w_slot_msg    = i_s_tdata[8:5];
    assign w_slot_gap    = i_s_tdata[24:9];
    assign w_table_is_tx = i_s_tdata[25];
    assign w_msg_id      = i_s_tdata[31:26];
    assign w_msg_dlc     = i_s_tdata[35:32];
    assign w_frame_id    = i_s_tdata[43:36];
    assign w_frame_dlc   = i_s_tdata[47:44];
    assign w_frame_data  = i_s_tdata[111:48];

    assign w_acc         = i_s_tvalid && o_s_tready;
    assign w_idx_ext     = {3'b000, w_idx};
    assign w_idx_slot_ok = w_idx_ext < 7'(SLOTS);
    assign w_idx_msg_ok  = w_idx_ext < 7'(MSG_ENTRIES);

    // Memory ports.
    logic              w_sch_re;
    logic [SCH_W-1:0]  w_sch_q;
    logic              w_rxt_re;
    logic [MA_W-1:0]   w_rxt_raddr;
    logic [9:0]        w_rxt_q;
    logic              w_txt_re;
    logic [9:0]        w_txt_q;
    logic [63:0]       w_txd_q;
    logic              w_stat_re;
    logic [MA_W-1:0]   w_stat_raddr;
    logic              w_stat_we;
    logic [MA_W-1:0]   w_stat_waddr;
    logic [STAT_W-1:0] w_stat_wdata;
    logic [STAT_W-1:0] w_stat_q;

    // Schedule entry decode on the read data.
    logic              w_sch_tx;
    logic [6:0]        w_sch_msg_ext;
    logic              w_sch_msg_ok;
    logic [MA_W-1:0]   w_sch_msg_addr;

    assign w_sch_tx       = w_sch_q[SCH_W-1];
    assign w_sch_msg_ext  = {3'b000, w_sch_q[SCH_W-2 -: 4]};
    assign w_sch_msg_ok   = w_sch_msg_ext < 7'(MSG_ENTRIES);
    assign w_sch_msg_addr = w_sch_msg_ext[MA_W-1:0];

    // Gap countdown and slot advance.
    logic [GAP_BITS-1:0] w_gap_dec;
    logic [SA_W:0]       w_pos_nxt;
    logic                w_pos_wrap;

    assign w_gap_dec  = (r_gap != '0) ? (r_gap - GAP_BITS'(1)) : '0;
    assign w_pos_nxt  = {1'b0, r_pos} + (SA_W + 1)'(1);
    assign w_pos_wrap = (7'(w_pos_nxt) >= {2'b00, r_slot_count}) ||
                        (7'(w_pos_nxt) >= 7'(SLOTS));

    // Receive table search bounds.
    logic [6:0]  w_lim;
    logic [MA_W:0] w_srch_nxt;
    logic        w_srch_done;
    logic        w_srch_hit;
    logic        w_frame_ok;

    assign w_lim       = ({2'b00, r_rx_count} < 7'(MSG_ENTRIES)) ?
                         {2'b00, r_rx_count} : 7'(MSG_ENTRIES);
    assign w_srch_nxt  = {1'b0, r_srch_i} + (MA_W + 1)'(1);
    assign w_srch_done = 7'(w_srch_nxt) >= w_lim;
    assign w_srch_hit  = w_rxt_q[9:4] == r_fid;
    assign w_frame_ok  = (w_frame_id <= lmse_pkg::MAX_LIN_ID) && (w_lim != '0);

    // Status read data with never-written entries reading as zero.
    logic [1:0]  w_old_flags;
    logic [63:0] w_old_data;
    logic [63:0] w_frame_mask;
    logic [1:0]  w_tick_flags;

    assign w_old_flags  = r_stat_rv ? w_stat_q[65:64] : 2'b00;
    assign w_old_data   = r_stat_rv ? w_stat_q[63:0] : 64'd0;
    assign w_frame_mask = lmse_pkg::byte_mask(r_fdlc);
    assign w_tick_flags = w_old_flags[0] ? 2'b00 : (w_old_flags | 2'b10);

    // Memories.
    lmse_ram #(.WIDTH(SCH_W), .DEPTH(SLOTS), .AW(SA_W)) u_sched (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_cmd == lmse_pkg::CMD_WR_SLOT) && w_idx_slot_ok),
        .i_waddr (w_idx_ext[SA_W-1:0]),
        .i_wdata ({w_slot_is_tx, w_slot_msg, GAP_BITS'(w_slot_gap)}),
        .i_re    (w_sch_re),
        .i_raddr (r_pos),
        .o_rdata (w_sch_q)
    );

    lmse_ram #(.WIDTH(10), .DEPTH(MSG_ENTRIES), .AW(MA_W)) u_rx_tab (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_cmd == lmse_pkg::CMD_WR_MSG) && w_idx_msg_ok && !w_table_is_tx),
        .i_waddr (w_idx_ext[MA_W-1:0]),
        .i_wdata ({w_msg_id, w_msg_dlc}),
        .i_re    (w_rxt_re),
        .i_raddr (w_rxt_raddr),
        .o_rdata (w_rxt_q)
    );

    lmse_ram #(.WIDTH(10), .DEPTH(MSG_ENTRIES), .AW(MA_W)) u_tx_tab (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_cmd == lmse_pkg::CMD_WR_MSG) && w_idx_msg_ok && w_table_is_tx),
        .i_waddr (w_idx_ext[MA_W-1:0]),
        .i_wdata ({w_msg_id, w_msg_dlc}),
        .i_re    (w_txt_re),
        .i_raddr (w_sch_msg_addr),
        .o_rdata (w_txt_q)
    );

    lmse_ram #(.WIDTH(64), .DEPTH(MSG_ENTRIES), .AW(MA_W)) u_tx_dat (
        .i_clk   (i_clk),
        .i_we    (w_acc && (w_cmd == lmse_pkg::CMD_WR_TXD) && w_idx_msg_ok),
        .i_waddr (w_idx_ext[MA_W-1:0]),
        .i_wdata (w_frame_data),
        .i_re    (w_txt_re),
        .i_raddr (w_sch_msg_addr),
        .o_rdata (w_txd_q)
    );

    // Receive status: {timeout, received, data}.
    lmse_ram #(.WIDTH(STAT_W), .DEPTH(MSG_ENTRIES), .AW(MA_W)) u_rx_stat (
        .i_clk   (i_clk),
        .i_we    (w_stat_we),
        .i_waddr (w_stat_waddr),
        .i_wdata (w_stat_wdata),
        .i_re    (w_stat_re),
        .i_raddr (w_stat_raddr),
        .o_rdata (w_stat_q)
    );

    // Configuration writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable     <= 1'b0;
            r_slot_count <= 5'd1;
            r_rx_count   <= 5'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lmse_pkg::CFG_ENABLE:     r_enable     <= i_cfg_data[0];
                lmse_pkg::CFG_SLOT_COUNT: r_slot_count <= i_cfg_data;
                lmse_pkg::CFG_RX_COUNT:   r_rx_count   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lmse_pkg::ST_IDLE: begin
                if (w_acc) begin
                    unique case (w_cmd)
                        lmse_pkg::CMD_TICK: begin
                            if (r_enable && (w_gap_dec == '0)) begin
                                n_state = lmse_pkg::ST_TK_SLOT;
                            end
                        end
                        lmse_pkg::CMD_FRAME: begin
                            if (w_frame_ok) begin
                                n_state = lmse_pkg::ST_SR_CHK;
                            end
                        end
                        lmse_pkg::CMD_RD_RX: begin
                            n_state = w_idx_msg_ok ? lmse_pkg::ST_RD_DATA : lmse_pkg::ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            lmse_pkg::ST_TK_SLOT: n_state = lmse_pkg::ST_TK_MSG;
            lmse_pkg::ST_TK_MSG:  n_state = lmse_pkg::ST_TK_GAP;
            lmse_pkg::ST_TK_GAP:  n_state = lmse_pkg::ST_EMIT;
            lmse_pkg::ST_SR_CHK: begin
                if (w_srch_hit) begin
                    n_state = lmse_pkg::ST_SR_UPD;
                end else if (w_srch_done) begin
                    n_state = lmse_pkg::ST_IDLE;
                end
            end
            lmse_pkg::ST_SR_UPD:  n_state = lmse_pkg::ST_IDLE;
            lmse_pkg::ST_RD_DATA: n_state = lmse_pkg::ST_EMIT;
            lmse_pkg::ST_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = lmse_pkg::ST_IDLE;
                end
            end
            default: n_state = lmse_pkg::ST_IDLE;
        endcase
    end

    // Handshake and memory controls per state.
    always_comb begin
        o_s_tready   = 1'b0;
        w_sch_re     = 1'b0;
        w_rxt_re     = 1'b0;
        w_rxt_raddr  = w_idx_ext[MA_W-1:0];
        w_txt_re     = 1'b0;
        w_stat_re    = 1'b0;
        w_stat_raddr = w_idx_ext[MA_W-1:0];
        w_stat_we    = 1'b0;
        w_stat_waddr = r_srch_i;
        w_stat_wdata = {2'b01, w_old_data};
        unique case (r_state)
            lmse_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (w_acc && (w_cmd == lmse_pkg::CMD_TICK)) begin
                    w_sch_re = 1'b1;
                end
                if (w_acc && (w_cmd == lmse_pkg::CMD_FRAME)) begin
                    w_rxt_re    = 1'b1;
                    w_rxt_raddr = '0;
                end
                if (w_acc && (w_cmd == lmse_pkg::CMD_RD_RX)) begin
                    w_rxt_re  = 1'b1;
                    w_stat_re = 1'b1;
                end
            end
            lmse_pkg::ST_TK_SLOT: begin
                w_rxt_re     = 1'b1;
                w_rxt_raddr  = w_sch_msg_addr;
                w_txt_re     = 1'b1;
                w_stat_re    = 1'b1;
                w_stat_raddr = w_sch_msg_addr;
            end
            lmse_pkg::ST_TK_MSG: begin
                // Next slot gap comes from the updated position.
                w_sch_re     = 1'b1;
                w_stat_we    = !r_slot_tx && r_slot_ok;
                w_stat_waddr = r_slot_msg;
                w_stat_wdata = {w_tick_flags, w_old_data};
            end
            lmse_pkg::ST_SR_CHK: begin
                w_rxt_re     = 1'b1;
                w_rxt_raddr  = w_srch_nxt[MA_W-1:0];
                w_stat_re    = w_srch_hit;
                w_stat_raddr = r_srch_i;
            end
            lmse_pkg::ST_SR_UPD: begin
                // Received set, timeout cleared, matching length merges the bytes.
                w_stat_we    = 1'b1;
                w_stat_waddr = r_srch_i;
                w_stat_wdata = r_dlc_ok ?
                    {2'b01, (w_old_data & ~w_frame_mask) | (r_fdata & w_frame_mask)} :
                    {2'b01, w_old_data};
            end
            default: ;
        endcase
    end

    // Sequencer state and status valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lmse_pkg::ST_IDLE;
            r_pos      <= '0;
            r_gap      <= '0;
            r_stat_vld <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == lmse_pkg::ST_IDLE) && w_acc && (w_cmd == lmse_pkg::CMD_TICK) &&
                r_enable) begin
                r_gap <= w_gap_dec;
            end
            if (r_state == lmse_pkg::ST_TK_SLOT) begin
                r_pos <= w_pos_wrap ? '0 : w_pos_nxt[SA_W-1:0];
            end
            if (r_state == lmse_pkg::ST_TK_GAP) begin
                r_gap <= w_sch_q[GAP_BITS-1:0];
            end
            if (w_stat_we) begin
                r_stat_vld[w_stat_waddr] <= 1'b1;
            end
        end
    end

    // Working registers and result assembly.
    always_ff @(posedge i_clk) begin
        if (w_stat_re) begin
            r_stat_rv <= r_stat_vld[w_stat_raddr];
        end
        unique case (r_state)
            lmse_pkg::ST_IDLE: begin
                r_srch_i <= '0;
                r_fid    <= w_frame_id[5:0];
                r_fdlc   <= w_frame_dlc;
                r_fdata  <= w_frame_data;
                // An out of range status read answers with zeros.
                r_res    <= '{kind: lmse_pkg::KIND_STATUS, id: 6'd0, dlc: 4'd0,
                              data: 64'd0, rcv: 1'b0, tmo: 1'b0};
            end
            lmse_pkg::ST_TK_SLOT: begin
                r_slot_tx  <= w_sch_tx;
                r_slot_ok  <= w_sch_msg_ok;
                r_slot_msg <= w_sch_msg_addr;
            end
            lmse_pkg::ST_TK_MSG: begin
                if (r_slot_tx) begin
                    r_res.kind <= lmse_pkg::KIND_FRAME;
                    r_res.id   <= r_slot_ok ? w_txt_q[9:4] : 6'd0;
                    r_res.dlc  <= r_slot_ok ? w_txt_q[3:0] : 4'd0;
                    r_res.data <= r_slot_ok ?
                                  (w_txd_q & lmse_pkg::byte_mask(w_txt_q[3:0])) : 64'd0;
                end else begin
                    r_res.kind <= lmse_pkg::KIND_HEADER;
                    r_res.id   <= r_slot_ok ? w_rxt_q[9:4] : 6'd0;
                    r_res.dlc  <= r_slot_ok ? w_rxt_q[3:0] : 4'd0;
                    r_res.data <= 64'd0;
                end
                r_res.rcv <= 1'b0;
                r_res.tmo <= 1'b0;
            end
            lmse_pkg::ST_SR_CHK: begin
                if (!w_srch_hit) begin
                    r_srch_i <= w_srch_nxt[MA_W-1:0];
                end
                r_dlc_ok <= w_rxt_q[3:0] == r_fdlc;
            end
            lmse_pkg::ST_RD_DATA: begin
                r_res <= '{kind: lmse_pkg::KIND_STATUS, id: w_rxt_q[9:4],
                           dlc: w_rxt_q[3:0], data: w_old_data,
                           rcv: w_old_flags[0], tmo: w_old_flags[1]};
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == lmse_pkg::ST_EMIT) && (!r_out_valid || i_m_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == lmse_pkg::ST_EMIT) && (!r_out_valid || i_m_tready)) begin
            r_out <= r_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {4'b0000, r_out.tmo, r_out.rcv, r_out.data, r_out.dlc, r_out.id};

    // Checks.
    `LMSE_ASSERT_ALWAYS(a_pos_range, 7'(r_pos) < 7'(SLOTS), "slot position out of range")
    `LMSE_ASSERT_IMP(a_gap_zero_on_serve, r_state == lmse_pkg::ST_TK_SLOT, r_gap == '0, "slot served with nonzero gap")
    `LMSE_ASSERT_IMP(a_srch_bound, r_state == lmse_pkg::ST_SR_CHK, 7'(r_srch_i) < w_lim, "search index beyond rx_count")
    `LMSE_ASSERT_NEXT(a_emit_loads, (r_state == lmse_pkg::ST_EMIT) && (!r_out_valid || i_m_tready), o_m_tvalid && (r_state == lmse_pkg::ST_IDLE), "result not loaded")

endmodule

`default_nettype wire
